[rtl/pfb_pkg.sv]
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared codes, constants and pipeline stage types of the framebuffer packer.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_PIXEL_FORMAT      = 2'd0;
   localparam logic [1:0] CSR_TRANSPARENCY_MODE = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH       = 2'd2;
   localparam logic [1:0] CSR_IMAGE_HEIGHT      = 2'd3;

   // pixel formats
   localparam logic [1:0] FMT_BINARY = 2'd0;
   localparam logic [1:0] FMT_GRAY   = 2'd1;
   localparam logic [1:0] FMT_RGB565 = 2'd2;
   localparam logic [1:0] FMT_RGB888 = 2'd3;

   // transparency modes
   localparam logic [1:0] TR_OPAQUE   = 2'd0;
   localparam logic [1:0] TR_CHROMA   = 2'd1;
   localparam logic [1:0] TR_ALPHA    = 2'd2;
   localparam logic [1:0] TR_RESERVED = 2'd3;

   // luma weights, Q0.16
   localparam logic [15:0] GRAY_WEIGHT_RED   = 16'd13926;
   localparam logic [15:0] GRAY_WEIGHT_GREEN = 16'd46884;
   localparam logic [15:0] GRAY_WEIGHT_BLUE  = 16'd4725;

   localparam logic [7:0] ALPHA_HALF   = 8'h80;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] MASK_LEFT    = 8'h80;
   localparam logic [7:0] MASK_ALL     = 8'hFF;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   // after input register: coordinates already range checked
   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        in_image;
   } s1_type;

   // after the multiply stage
   typedef struct packed {
      logic [11:0] x;
      logic [24:0] row_base;
      logic [23:0] prod_red;
      logic [23:0] prod_green;
      logic [23:0] prod_blue;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        bin_on;
      logic        in_image;
   } s2_type;

   // after linear position and byte formatting
   typedef struct packed {
      logic [24:0] pos;
      logic [2:0]  count;
      logic [7:0]  data0;
      logic [7:0]  data1;
      logic [7:0]  data2;
      logic [7:0]  data3;
      logic        in_image;
   } s3_type;

   // output register
   typedef struct packed {
      logic        status;
      logic [23:0] byte_address;
      logic [2:0]  byte_count;
      logic [7:0]  data_byte0;
      logic [7:0]  data_byte1;
      logic [7:0]  data_byte2;
      logic [7:0]  data_byte3;
      logic [7:0]  bit_mask;
   } s4_type;

endpackage

`default_nettype wire

[rtl/pixel_to_framebuffer_packer.sv]
// ----------------------------------------------------------------------------
// pixel_to_framebuffer_packer
// Turns one pixel into the framebuffer byte write it causes.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one pixel per transfer (x, y, red, green, blue,
//   alpha). rsp channel carries the matching write: status in tuser, then
//   byte address, byte count, four data bytes and the bit mask in tdata.
//   csr port sets format, transparency mode and image size; write it only
//   while no pixel is in flight.
// Timing:
//   four register stages (input/range check, multiplies, position and byte
//   formatting, address scaling/output). A pixel accepted on req passes
//   through the four registers in order before rsp can take it. One pixel
//   per cycle sustained while rsp_tready is high; the rate is set by the
//   stage chain, every stage takes a new pixel each cycle when not stalled.
// Reset:
//   returns registers to rgb888, opaque, 1 x 1 and empties the pipeline.
// Stall:
//   when rsp_tready is low the output holds; earlier stages keep filling
//   bubbles and req_tready drops only once all stages hold a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_framebuffer_packer
   import pfb_pkg::*;
#(
   parameter int MAX_DIMENSION = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // csr write port
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [11:0]           csr_wdata,
   // pixel input
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // tdata: pixel_x[12:0], pixel_y[25:13], red[33:26], green[41:34],
   //        blue[49:42], alpha[57:50], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // write output
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: byte_address[23:0], byte_count[26:24], data_byte0[34:27],
   //        data_byte1[42:35], data_byte2[50:43], data_byte3[58:51],
   //        bit_mask[66:59], zero fill
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status[0]
   output      logic [0:0]            rsp_tuser
);

   logic [1:0]  format_ff;
   logic [1:0]  trans_ff;
   logic [11:0] width_ff;
   logic [11:0] height_ff;
   logic [11:0] dim_in;
   logic [1:0]  tr_eff;

   // dimensions are stored already saturated to the maximum
   assign dim_in = ({20'd0, csr_wdata} > 32'(MAX_DIMENSION)) ? 12'(MAX_DIMENSION)
                                                              : csr_wdata;
   assign tr_eff = (trans_ff == TR_RESERVED) ? TR_OPAQUE : trans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_RGB888;
         trans_ff  <= TR_OPAQUE;
         width_ff  <= 12'd1;
         height_ff <= 12'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PIXEL_FORMAT:      format_ff <= csr_wdata[1:0];
            CSR_TRANSPARENCY_MODE: trans_ff  <= csr_wdata[1:0];
            CSR_IMAGE_WIDTH:       width_ff  <= dim_in;
            CSR_IMAGE_HEIGHT:      height_ff <= dim_in;
            default: begin
            end
         endcase
      end
   end

   logic   s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic   s1_en, s2_en, s3_en, s4_en;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;

   // a stage loads when it is empty or its content moves on
   assign s4_en      = !s4_valid_ff || rsp_tready;
   assign s3_en      = !s3_valid_ff || s4_en;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_tvalid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) s1_ff <= s1_in;
      if (s2_en) s2_ff <= s2_in;
      if (s3_en) s3_ff <= s3_in;
      if (s4_en) s4_ff <= s4_in;
   end

   // stage 1: unpack and range check
   always_comb begin
      logic [12:0] px;
      logic [12:0] py;
      px = req_tdata[12:0];
      py = req_tdata[25:13];
      s1_in.x      = px[11:0];
      s1_in.y      = py[11:0];
      s1_in.red    = req_tdata[33:26];
      s1_in.green  = req_tdata[41:34];
      s1_in.blue   = req_tdata[49:42];
      s1_in.alpha  = req_tdata[57:50];
      s1_in.in_image = !px[12] && !py[12] && (px[11:0] < width_ff)
                       && (py[11:0] < height_ff);
   end

   // stage 2: row offset, luma products and binary threshold
   always_comb begin
      logic [12:0] width_pad;
      logic [12:0] row_width;
      logic [7:0]  bin_sum;
      width_pad = ({1'b0, width_ff} + 13'd7) & ~13'd7;
      row_width = (format_ff == FMT_BINARY) ? width_pad : {1'b0, width_ff};
      bin_sum   = {2'b00, s1_ff.red[7:2]} + {1'b0, s1_ff.green[7:1]}
                  + {2'b00, s1_ff.blue[7:2]};
      s2_in.x          = s1_ff.x;
      s2_in.row_base   = 25'(s1_ff.y) * 25'(row_width);
      s2_in.prod_red   = 24'(s1_ff.red) * 24'(GRAY_WEIGHT_RED);
      s2_in.prod_green = 24'(s1_ff.green) * 24'(GRAY_WEIGHT_GREEN);
      s2_in.prod_blue  = 24'(s1_ff.blue) * 24'(GRAY_WEIGHT_BLUE);
      s2_in.red        = s1_ff.red;
      s2_in.green      = s1_ff.green;
      s2_in.blue       = s1_ff.blue;
      s2_in.alpha      = s1_ff.alpha;
      s2_in.bin_on     = bin_sum[7] &&
                         !((tr_eff != TR_OPAQUE) && (s1_ff.alpha < ALPHA_HALF));
      s2_in.in_image   = s1_ff.in_image;
   end

   // stage 3: linear position and data bytes
   always_comb begin
      logic [23:0] luma_sum;
      logic [7:0]  gray;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic        is565;
      logic [2:0]  cnt;
      logic [7:0]  d0, d1, d2, d3;
      luma_sum = s2_ff.prod_red + s2_ff.prod_green + s2_ff.prod_blue;
      gray     = luma_sum[23:16];
      r        = s2_ff.red;
      g        = s2_ff.green;
      b        = s2_ff.blue;
      is565    = (format_ff == FMT_RGB565);
      cnt      = 3'd1;
      d0       = 8'd0;
      d1       = 8'd0;
      d2       = 8'd0;
      d3       = 8'd0;
      case (format_ff)
         FMT_BINARY: begin
            d0 = s2_ff.bin_on ? 8'hFF : 8'h00;
         end
         FMT_GRAY: begin
            if (tr_eff == TR_CHROMA) begin
               if (gray == 8'd1) gray = 8'd0;
               if (s2_ff.alpha < ALPHA_HALF) gray = 8'd1;
            end else if (tr_eff == TR_ALPHA) begin
               if (s2_ff.alpha != ALPHA_OPAQUE) gray = s2_ff.alpha;
            end
            d0 = gray;
         end
         default: begin
            if (tr_eff == TR_CHROMA) begin
               // pure rgb888 key green is pulled off the key, transparent goes onto it
               if (g == 8'd1 && r == 8'd0 && b == 8'd0) g = 8'd0;
               if (s2_ff.alpha < ALPHA_HALF) begin
                  r = 8'd0;
                  g = is565 ? 8'd4 : 8'd1;
                  b = 8'd0;
               end
            end
            if (is565) begin
               d0  = {r[7:3], g[7:5]};
               d1  = {g[4:2], b[7:3]};
               cnt = 3'd2;
               if (tr_eff == TR_ALPHA) begin
                  d2  = s2_ff.alpha;
                  cnt = 3'd3;
               end
            end else begin
               d0  = r;
               d1  = g;
               d2  = b;
               cnt = 3'd3;
               if (tr_eff == TR_ALPHA) begin
                  d3  = s2_ff.alpha;
                  cnt = 3'd4;
               end
            end
         end
      endcase
      s3_in.pos      = {13'd0, s2_ff.x} + s2_ff.row_base;
      s3_in.count    = cnt;
      s3_in.data0    = d0;
      s3_in.data1    = d1;
      s3_in.data2    = d2;
      s3_in.data3    = d3;
      s3_in.in_image = s2_ff.in_image;
   end

   // stage 4: byte address scaling, mask, out-of-image result
   always_comb begin
      logic [26:0] pos_w;
      logic [26:0] addr;
      pos_w = {2'b00, s3_ff.pos};
      case (s3_ff.count)
         3'd2:    addr = pos_w << 1;
         3'd3:    addr = pos_w + (pos_w << 1);
         3'd4:    addr = pos_w << 2;
         default: addr = pos_w;
      endcase
      if (format_ff == FMT_BINARY) addr = pos_w >> 3;
      if (s3_ff.in_image) begin
         s4_in.status       = 1'b0;
         s4_in.byte_address = addr[23:0];
         s4_in.byte_count   = s3_ff.count;
         s4_in.data_byte0   = s3_ff.data0;
         s4_in.data_byte1   = s3_ff.data1;
         s4_in.data_byte2   = s3_ff.data2;
         s4_in.data_byte3   = s3_ff.data3;
         s4_in.bit_mask     = (format_ff == FMT_BINARY) ? (MASK_LEFT >> s3_ff.pos[2:0])
                                                         : MASK_ALL;
      end else begin
         s4_in = '0;
         s4_in.status = 1'b1;
      end
   end

   assign rsp_tvalid   = s4_valid_ff;
   assign rsp_tuser[0] = s4_ff.status;
   assign rsp_tdata    = {5'd0, s4_ff.bit_mask, s4_ff.data_byte3, s4_ff.data_byte2,
                          s4_ff.data_byte1, s4_ff.data_byte0, s4_ff.byte_count,
                          s4_ff.byte_address};

endmodule

`default_nettype wire

[rtl/pfb_checker.sv]
// ----------------------------------------------------------------------------
// pfb_checker
// Port-level checks on the framebuffer packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_checker
   import pfb_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [0:0]            rsp_tuser
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set after reset");

   // empty output stage means nothing blocks the input
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output empty");

   // a stalled transfer holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled rsp transfer changed");

   // out-of-image pixel gives an all-zero write
   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("error status with nonzero write");

   // a valid write moves one to four bytes
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[26:24] != 3'd0
                                      && rsp_tdata[26:24] <= 3'd4)
      else $error("byte count out of range");

endmodule

bind pixel_to_framebuffer_packer pfb_checker u_pfb_checker (.*);

`default_nettype wire
